@@ hw/rtl/websocket_frame_deframer_assert.svh @@
// Assertion macros used by the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define WSFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define WSFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/wsfd_pkg.sv @@
`timescale 1ns / 1ps

package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE           = 2'd0,
        ERR_CTRL_NOT_FINAL = 2'd1,
        ERR_CONT_SEQ       = 2'd2,
        ERR_MASK           = 2'd3
    } err_t;

    localparam logic [3:0] OPC_CONT      = 4'h0;
    localparam logic [6:0] LEN_EXT16     = 7'h7E;
    localparam logic [6:0] LEN_EXT64     = 7'h7F;
    localparam logic [2:0] EXT16_COUNT   = 3'd1;
    localparam logic [2:0] EXT64_COUNT   = 3'd7;
    localparam logic [1:0] KEY_LAST_IDX  = 2'd3;
    localparam logic       ROLE_RESET    = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        kind_t      result_kind;
        logic [7:0] data_byte;
        logic       message_done;
        logic [3:0] message_opcode;
        err_t       error_code;
    } result_t;

endpackage

@@ hw/rtl/wsfd_stream_if.sv @@
`timescale 1ns / 1ps

// Valid/ready stream channel; one transfer per edge with valid and ready high.
interface wsfd_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps

// Receive-side WebSocket frame parser. Takes one stream byte per transfer on
// rx and returns exactly one result per byte on result, in the cycle after the
// byte is taken: header byte consumed, unmasked payload byte, or error, with
// message_done/message_opcode marking the byte that ends a final frame.
// Throughput is one byte per clock; rx.ready drops only while a finished
// result sits in the result register and result.ready is low. There is no
// clearing pass after reset. role_is_server (reset 1) selects whether incoming
// frames must be masked; write it only while no byte is in flight.

module websocket_frame_deframer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    wsfd_stream_if.sink   rx,
    wsfd_stream_if.source result
);

    // role register
    logic role_reg;

    // per-byte transfer control
    logic              can_load;
    logic              step;
    wsfd_pkg::result_t parse_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            role_reg <= wsfd_pkg::ROLE_RESET;
        else if (cfg_wr_en)
            role_reg <= cfg_wr_data;
    end

    // a byte transfers whenever the result register is free or draining
    assign rx.ready = can_load;
    assign step     = rx.valid && can_load;

    // parse state advances only on a transfer
    wsfd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .rx_byte        (rx.payload.rx_byte),
        .role_is_server (role_reg),
        .res            (parse_res)
    );

    // result register decouples the two sides
    wsfd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .res_in   (parse_res),
        .can_load (can_load),
        .res_out  (result)
    );

endmodule

@@ hw/rtl/wsfd_parser.sv @@
`timescale 1ns / 1ps

// Frame state plus the per-byte parse/unmask logic.
module wsfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              role_is_server,
    output wsfd_pkg::result_t res
);

    wsfd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       ext_cnt_reg, ext_cnt_next;
    logic [63:0]      rem_reg, rem_next;
    logic [31:0]      key_reg, key_next;
    logic             mask_present_reg, mask_present_next;
    logic [1:0]       idx_reg, idx_next;
    logic             final_reg, final_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic [3:0]       pending_reg, pending_next;
    wsfd_pkg::err_t   err_reg, err_next;

    logic       hdr_done;
    logic       frame_end;
    logic [7:0] key_byte;
    logic [3:0] opc;
    logic       fin;
    logic [6:0] len;

    assign opc      = rx_byte[3:0];
    assign fin      = rx_byte[7];
    assign len      = rx_byte[6:0];
    // key bytes are used most significant first
    assign key_byte = key_reg[{~idx_reg, 3'b000} +: 8];

    always_comb
    begin
        phase_next        = phase_reg;
        ext_cnt_next      = ext_cnt_reg;
        rem_next          = rem_reg;
        key_next          = key_reg;
        mask_present_next = mask_present_reg;
        idx_next          = idx_reg;
        final_next        = final_reg;
        opcode_next       = opcode_reg;
        pending_next      = pending_reg;
        err_next          = err_reg;
        hdr_done          = 1'b0;
        frame_end         = 1'b0;

        res.result_kind    = wsfd_pkg::KIND_HDR;
        res.data_byte      = 8'h00;
        res.message_done   = 1'b0;
        res.message_opcode = 4'h0;
        res.error_code     = wsfd_pkg::ERR_NONE;

        if (err_reg != wsfd_pkg::ERR_NONE)
        begin
            res.result_kind = wsfd_pkg::KIND_ERR;
            res.error_code  = err_reg;
        end
        else
        begin
            unique case (phase_reg)
                wsfd_pkg::PH_HDR0:
                begin
                    if (opc[3])
                    begin
                        if (!fin)
                            err_next = wsfd_pkg::ERR_CTRL_NOT_FINAL;
                    end
                    else if ((opc == wsfd_pkg::OPC_CONT) == (pending_reg == wsfd_pkg::OPC_CONT))
                    begin
                        err_next = wsfd_pkg::ERR_CONT_SEQ;
                    end

                    if (err_next != wsfd_pkg::ERR_NONE)
                    begin
                        res.result_kind = wsfd_pkg::KIND_ERR;
                        res.error_code  = err_next;
                    end
                    else
                    begin
                        final_next  = fin;
                        opcode_next = opc;
                        if (!fin && opc != wsfd_pkg::OPC_CONT)
                            pending_next = opc;
                        phase_next = wsfd_pkg::PH_HDR1;
                    end
                end
                wsfd_pkg::PH_HDR1:
                begin
                    if (rx_byte[7] != role_is_server)
                    begin
                        err_next        = wsfd_pkg::ERR_MASK;
                        res.result_kind = wsfd_pkg::KIND_ERR;
                        res.error_code  = wsfd_pkg::ERR_MASK;
                    end
                    else
                    begin
                        mask_present_next = rx_byte[7];
                        key_next          = 32'h0;
                        rem_next          = 64'h0;
                        if (len < wsfd_pkg::LEN_EXT16)
                        begin
                            rem_next = {57'h0, len};
                            hdr_done = 1'b1;
                        end
                        else
                        begin
                            ext_cnt_next = (len == wsfd_pkg::LEN_EXT16) ?
                                           wsfd_pkg::EXT16_COUNT : wsfd_pkg::EXT64_COUNT;
                            phase_next   = wsfd_pkg::PH_EXT;
                        end
                    end
                end
                wsfd_pkg::PH_EXT:
                begin
                    rem_next = {rem_reg[55:0], rx_byte};
                    if (ext_cnt_reg == 3'd0)
                        hdr_done = 1'b1;
                    else
                        ext_cnt_next = ext_cnt_reg - 3'd1;
                end
                wsfd_pkg::PH_KEY:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (idx_reg == wsfd_pkg::KEY_LAST_IDX)
                    begin
                        idx_next = 2'd0;
                        if (rem_reg != 64'h0)
                            phase_next = wsfd_pkg::PH_DATA;
                        else
                            frame_end = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                wsfd_pkg::PH_DATA:
                begin
                    res.result_kind = wsfd_pkg::KIND_DATA;
                    if (mask_present_reg)
                    begin
                        res.data_byte = rx_byte ^ key_byte;
                        idx_next      = idx_reg + 2'd1;
                    end
                    else
                    begin
                        res.data_byte = rx_byte;
                    end
                    rem_next = rem_reg - 64'd1;
                    if (rem_next == 64'h0)
                        frame_end = 1'b1;
                end
                default:
                begin
                    phase_next = wsfd_pkg::PH_HDR0;
                end
            endcase

            if (hdr_done)
            begin
                idx_next = 2'd0;
                if (mask_present_next)
                    phase_next = wsfd_pkg::PH_KEY;
                else if (rem_next != 64'h0)
                    phase_next = wsfd_pkg::PH_DATA;
                else
                    frame_end = 1'b1;
            end

            if (frame_end)
            begin
                phase_next = wsfd_pkg::PH_HDR0;
                if (final_reg)
                begin
                    res.message_done = 1'b1;
                    if (opcode_reg == wsfd_pkg::OPC_CONT)
                    begin
                        res.message_opcode = pending_reg;
                        pending_next       = wsfd_pkg::OPC_CONT;
                    end
                    else
                    begin
                        res.message_opcode = opcode_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= wsfd_pkg::PH_HDR0;
            ext_cnt_reg      <= 3'd0;
            rem_reg          <= 64'h0;
            key_reg          <= 32'h0;
            mask_present_reg <= 1'b0;
            idx_reg          <= 2'd0;
            final_reg        <= 1'b0;
            opcode_reg       <= 4'h0;
            pending_reg      <= 4'h0;
            err_reg          <= wsfd_pkg::ERR_NONE;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            ext_cnt_reg      <= ext_cnt_next;
            rem_reg          <= rem_next;
            key_reg          <= key_next;
            mask_present_reg <= mask_present_next;
            idx_reg          <= idx_next;
            final_reg        <= final_next;
            opcode_reg       <= opcode_next;
            pending_reg      <= pending_next;
            err_reg          <= err_next;
        end
    end

endmodule

@@ hw/rtl/wsfd_out_stage.sv @@
`timescale 1ns / 1ps

// Result register; refills on the same edge the held result is taken.
module wsfd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  wsfd_pkg::result_t res_in,
    output logic              can_load,
    wsfd_stream_if.source     res_out
);

    logic              valid_reg;
    logic              valid_next;
    wsfd_pkg::result_t data_reg;

    assign can_load   = !valid_reg || res_out.ready;
    assign valid_next = load || (valid_reg && !res_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res_in;
    end

    assign res_out.valid   = valid_reg;
    assign res_out.payload = data_reg;

endmodule

@@ hw/rtl/wsfd_checker.sv @@
`timescale 1ns / 1ps
`include "websocket_frame_deframer_assert.svh"

module wsfd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              rx_ready,
    input logic              res_valid,
    input logic              res_ready,
    input wsfd_pkg::result_t res_payload
);

    logic           err_seen_reg;
    wsfd_pkg::err_t err_code_reg;
    logic           res_xfer;
    logic           res_is_err;
    logic           res_stall;
    logic           res_free;
    logic           err_match;
    logic           code_held;
    logic           not_data;
    logic           fields_clean;

    assign res_xfer     = res_valid && res_ready;
    assign res_is_err   = res_payload.result_kind == wsfd_pkg::KIND_ERR;
    assign res_stall    = res_valid && !res_ready;
    assign res_free     = rst_n && (!res_valid || res_ready);
    assign err_match    = res_is_err == (res_payload.error_code != wsfd_pkg::ERR_NONE);
    assign code_held    = res_is_err && (res_payload.error_code == err_code_reg);
    assign not_data     = res_payload.result_kind != wsfd_pkg::KIND_DATA;
    assign fields_clean = (res_payload.data_byte == 8'h00) &&
                          !(res_is_err && res_payload.message_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg <= 1'b0;
            err_code_reg <= wsfd_pkg::ERR_NONE;
        end
        else if (res_xfer && res_is_err && !err_seen_reg)
        begin
            err_seen_reg <= 1'b1;
            err_code_reg <= res_payload.error_code;
        end
    end

    `WSFD_ASSERT(a_stall_hold, res_stall |=> res_valid && $stable(res_payload), "result not held")

    `WSFD_ASSERT(a_err_code, res_valid |-> err_match, "error code and kind disagree")

    `WSFD_ASSERT(a_sticky, res_valid && err_seen_reg |-> code_held, "error not sticky")

    `WSFD_ASSERT(a_fields, res_valid && not_data |-> fields_clean, "stray data or done")

    `WSFD_ASSERT_ALWAYS(a_rate, res_free |-> rx_ready, "input stalled with result path free")

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_ready    (rx.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_payload (result.payload)
);

@@ tb/sv/tb_websocket_frame_deframer.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the receive-side WebSocket deframer.
// Every accepted rx byte produces exactly one result; the bench predicts it
// in lockstep and checks the result stream in order.

module tb_websocket_frame_deframer;

    import wsfd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 600000;  // far above the slowest legal run
    localparam int PHASE_BYTES  = 250;     // random bytes per config setting
    localparam int NUM_PHASES   = 6;
    localparam int DRAIN_CYCLES = 4;       // settle time after the queue empties
    localparam int HOLD_CYCLES  = 400;     // long result-side hold-off
    localparam int NOISE_BYTES  = 6;
    localparam int ENDLESS_BYTES = 20;

    // Header bytes and key bytes all come back as a bare "consumed" result.
    localparam result_t R_HDR = '{KIND_HDR, 8'h00, 1'b0, 4'h0, ERR_NONE};

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       typed;     // 1: use exp below, 0: take the predictor's result
        result_t    exp;
    } dir_row_t;

    // Directed frames, role = server (masked), as after reset:
    //   text fragment, not final, empty payload behind a mask key
    //   final ping inside the open message, 1 masked byte
    //   final continuation with RSV bits set, 16-bit extended length of 2
    localparam int DIR_N = 23;
    localparam dir_row_t DIR_TABLE [DIR_N] = '{
        '{8'h01, 1'b1, R_HDR},
        '{8'h80, 1'b1, R_HDR},
        '{8'hAA, 1'b1, R_HDR},
        '{8'h55, 1'b1, R_HDR},
        '{8'h00, 1'b1, R_HDR},
        '{8'hFF, 1'b1, R_HDR},
        '{8'h89, 1'b1, R_HDR},
        '{8'h81, 1'b1, R_HDR},
        '{8'h12, 1'b1, R_HDR},
        '{8'h34, 1'b1, R_HDR},
        '{8'h56, 1'b1, R_HDR},
        '{8'h78, 1'b1, R_HDR},
        '{8'hFF, 1'b1, '{KIND_DATA, 8'hED, 1'b1, 4'h9, ERR_NONE}},
        '{8'hF0, 1'b1, R_HDR},
        '{8'hFE, 1'b1, R_HDR},
        '{8'h00, 1'b1, R_HDR},
        '{8'h02, 1'b1, R_HDR},
        '{8'hFF, 1'b1, R_HDR},
        '{8'hFF, 1'b1, R_HDR},
        '{8'hFF, 1'b1, R_HDR},
        '{8'hFF, 1'b1, R_HDR},
        '{8'h00, 1'b1, '{KIND_DATA, 8'hFF, 1'b0, 4'h0, ERR_NONE}},
        '{8'hFF, 1'b0, R_HDR}
    };

    // Settings walked by the random phases; both roles, each more than once.
    localparam logic PHASE_ROLE [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    localparam int NO_IDLE_PHASE  = 2;
    localparam int PRESSURE_PHASE = 3;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    wsfd_stream_if #(.payload_t(in_t))     rx_if ();
    wsfd_stream_if #(.payload_t(result_t)) result_if ();

    websocket_frame_deframer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .rx         (rx_if),
        .result     (result_if)
    );

    // ------------------------------------------------------------------
    // Clock and run-time limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    int cycle_cnt = 0;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_cnt);
            $display("[websocket_frame_deframer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    result_t   expect_q[$];       // predicted results, oldest first
    int        fail_cnt   = 0;
    int        sent_total = 0;
    bit        no_idle    = 1'b0; // both sides run flat out while set
    int        hold_req   = 0;    // bumped to ask the sink for a long hold-off
    int        hold_ack   = 0;

    // Side info for the byte currently offered on rx (directed rows only).
    logic      byte_typed = 1'b0;
    result_t   byte_exp   = '0;

    // ------------------------------------------------------------------
    // Frame parser prediction: shadow state, reset values as after rst_n
    // ------------------------------------------------------------------
    logic         role_pred  = ROLE_RESET;
    phase_t       ph         = PH_HDR0;
    logic [2:0]   ext_left   = '0;   // extended-length bytes still due, minus one
    logic [63:0]  remaining  = '0;
    logic [31:0]  key        = '0;
    logic         masked     = 1'b0;
    logic [1:0]   key_idx    = '0;
    logic         fin_cur    = 1'b0;
    logic [3:0]   op_cur     = '0;
    logic [3:0]   frag_op    = OPC_CONT;  // opcode of the open fragmented message
    err_t         err_hold   = ERR_NONE;

    function automatic result_t parse_byte(input logic [7:0] b);
        result_t    r;
        logic       hdr_complete;
        logic       frame_over;
        logic [7:0] k;
        int         sh;
        r            = '0;
        r.result_kind = KIND_HDR;
        r.error_code  = ERR_NONE;
        hdr_complete = 1'b0;
        frame_over   = 1'b0;
        k            = '0;

        // Errors stick: nothing moves until reset.
        if (err_hold != ERR_NONE)
        begin
            r.result_kind = KIND_ERR;
            r.error_code  = err_hold;
            return r;
        end

        case (ph)
            PH_HDR0:
            begin
                // Control frames must be final; continuation only inside a message.
                if (b[3])
                begin
                    if (!b[7])
                        err_hold = ERR_CTRL_NOT_FINAL;
                end
                else if ((b[3:0] == OPC_CONT) == (frag_op == OPC_CONT))
                begin
                    err_hold = ERR_CONT_SEQ;
                end
                if (err_hold != ERR_NONE)
                begin
                    r.result_kind = KIND_ERR;
                    r.error_code  = err_hold;
                    return r;
                end
                fin_cur = b[7];
                op_cur  = b[3:0];
                if (!b[7] && b[3:0] != OPC_CONT)
                    frag_op = b[3:0];
                ph = PH_HDR1;
            end
            PH_HDR1:
            begin
                if (b[7] != role_pred)
                begin
                    err_hold      = ERR_MASK;
                    r.result_kind = KIND_ERR;
                    r.error_code  = err_hold;
                    return r;
                end
                masked    = b[7];
                key       = '0;
                remaining = '0;
                if (b[6:0] < LEN_EXT16)
                begin
                    remaining    = 64'(b[6:0]);
                    hdr_complete = 1'b1;
                end
                else
                begin
                    ext_left = (b[6:0] == LEN_EXT16) ? EXT16_COUNT : EXT64_COUNT;
                    ph       = PH_EXT;
                end
            end
            PH_EXT:
            begin
                // Big-endian length, shifted in a byte at a time.
                remaining = {remaining[55:0], b};
                if (ext_left == 3'd0)
                    hdr_complete = 1'b1;
                else
                    ext_left = ext_left - 3'd1;
            end
            PH_KEY:
            begin
                key = {key[23:0], b};
                if (key_idx == KEY_LAST_IDX)
                begin
                    key_idx = '0;
                    if (remaining != 0)
                        ph = PH_DATA;
                    else
                        frame_over = 1'b1;
                end
                else
                begin
                    key_idx = key_idx + 2'd1;
                end
            end
            default:
            begin
                // Payload: key bytes rotate from the most significant one.
                if (masked)
                begin
                    sh      = 24 - 8 * int'(key_idx);
                    k       = key[sh +: 8];
                    key_idx = key_idx + 2'd1;
                end
                r.result_kind = KIND_DATA;
                r.data_byte   = b ^ k;
                remaining     = remaining - 64'd1;
                if (remaining == 0)
                    frame_over = 1'b1;
            end
        endcase

        if (hdr_complete)
        begin
            key_idx = '0;
            if (masked)
                ph = PH_KEY;
            else if (remaining != 0)
                ph = PH_DATA;
            else
                frame_over = 1'b1;
        end

        if (frame_over)
        begin
            ph = PH_HDR0;
            if (fin_cur)
            begin
                r.message_done = 1'b1;
                if (op_cur == OPC_CONT)
                begin
                    r.message_opcode = frag_op;
                    frag_op          = OPC_CONT;
                end
                else
                begin
                    r.message_opcode = op_cur;  // control or unfragmented data
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on each rx transfer, checks each result transfer
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $realtime, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t pred;
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (cfg_wr_en)
                role_pred = cfg_wr_data;
            if (rx_if.valid && rx_if.ready)
            begin
                pred = parse_byte(rx_if.payload.rx_byte);
                expect_q.push_back(byte_typed ? byte_exp : pred);
            end
            if (result_if.valid && result_if.ready)
            begin
                got = result_if.payload;
                if (expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, expected none got %h",
                             $realtime, got);
                    fail_cnt++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    check_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("message_done", 8'(want.message_done),
                                8'(got.message_done));
                    check_field("message_opcode", 8'(want.message_opcode),
                                8'(got.message_opcode));
                    check_field("error_code", 8'(want.error_code), 8'(got.error_code));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls, a few long ones, and one long hold-off
    // on request while the sender keeps pushing bytes.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        int r;
        stall_left      = 0;
        result_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack   = hold_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                result_if.ready = 1'b0;
                stall_left--;
            end
            else if (no_idle)
            begin
                result_if.ready = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    result_if.ready = 1'b1;
                end
                else
                begin
                    result_if.ready = 1'b0;
                    stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    logic       role_now  = ROLE_RESET;  // role as last written, for frame building
    bit         frag_open = 1'b0;        // a fragmented message is open on the wire
    logic [3:0] data_op   = 4'h1;        // rotate through all data opcodes
    logic [3:0] ctrl_op   = 4'h8;        // and all control opcodes

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one byte at the falling edge and hold it until it transfers.
    task automatic send_byte(input logic [7:0] b, input logic typed, input result_t exp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid           = 1'b1;
        rx_if.payload.rx_byte = b;
        byte_typed            = typed;
        byte_exp              = exp;
        do
            @(posedge clk);
        while (!rx_if.ready);
        sent_total++;
        @(negedge clk);
    endtask

    task automatic send_rand_byte(input logic [7:0] b);
        send_byte(b, 1'b0, R_HDR);
    endtask

    // First header byte of a legal frame given the open-message state.
    function automatic logic [7:0] legal_hdr0(input logic fin);
        logic [3:0] opc;
        if (frag_open)
        begin
            opc = OPC_CONT;
        end
        else
        begin
            opc     = data_op;
            data_op = (data_op == 4'h7) ? 4'h1 : data_op + 4'h1;
        end
        if (fin)
            frag_open = 1'b0;
        else
            frag_open = 1'b1;
        return {fin, 3'($urandom_range(0, 7)), opc};
    endfunction

    // One well-formed frame with random content and a random length form.
    task automatic send_frame();
        logic [7:0]  bytes_q[$];
        logic [63:0] len64;
        logic [3:0]  opc;
        int          len;
        int          r;
        if ($urandom_range(0, 99) < 25)
        begin
            // Final control frame; may land inside an open message.
            opc     = ctrl_op;
            ctrl_op = (ctrl_op == 4'hF) ? 4'h8 : ctrl_op + 4'h1;
            bytes_q.push_back({1'b1, 3'($urandom_range(0, 7)), opc});
        end
        else
        begin
            bytes_q.push_back(legal_hdr0(frag_open ? ($urandom_range(0, 1) == 1)
                                                   : ($urandom_range(0, 99) < 60)));
        end

        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            len = $urandom_range(0, 20);
            bytes_q.push_back({role_now, 7'(len)});
        end
        else if (r < 80)
        begin
            len = $urandom_range(21, 125);
            bytes_q.push_back({role_now, 7'(len)});
        end
        else if (r < 90)
        begin
            len = $urandom_range(0, 160);
            bytes_q.push_back({role_now, LEN_EXT16});
            bytes_q.push_back(len[15:8]);
            bytes_q.push_back(len[7:0]);
        end
        else
        begin
            len   = $urandom_range(0, 80);
            len64 = 64'(len);
            bytes_q.push_back({role_now, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
                bytes_q.push_back(len64[8 * i +: 8]);
        end

        if (role_now)
            repeat (4) bytes_q.push_back(8'($urandom_range(0, 255)));
        repeat (len) bytes_q.push_back(8'($urandom_range(0, 255)));

        foreach (bytes_q[i])
            send_rand_byte(bytes_q[i]);
    endtask

    // Wait until every prediction is matched, then let the pipe settle.
    task automatic wait_drained();
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_role(input logic v);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        role_now    = v;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int   phase_start;
        err_t tail_err;

        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = 1'b0;
        rx_if.valid           = 1'b0;
        rx_if.payload.rx_byte = 8'h00;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frames under the reset role.
        for (int i = 0; i < DIR_N; i++)
            send_byte(DIR_TABLE[i].rx_byte, DIR_TABLE[i].typed, DIR_TABLE[i].exp);
        rx_if.valid = 1'b0;
        byte_typed  = 1'b0;
        wait_drained();

        // Random frames, one role setting per phase; writes only when idle.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_role(PHASE_ROLE[p]);
            no_idle = (p == NO_IDLE_PHASE);
            if (p == PRESSURE_PHASE)
                hold_req++;
            phase_start = sent_total;
            while (sent_total - phase_start < PHASE_BYTES)
                send_frame();
            rx_if.valid = 1'b0;
            wait_drained();
        end
        no_idle = 1'b0;

        // Closing tail: one protocol violation (sticky from then on), or a
        // frame whose 64-bit length has the top bit set and never ends.
        tail_err = err_t'($urandom_range(0, 3));
        case (tail_err)
            ERR_CTRL_NOT_FINAL:
                send_rand_byte({1'b0, 3'($urandom_range(0, 7)), 1'b1,
                                3'($urandom_range(0, 7))});
            ERR_CONT_SEQ:
                if (frag_open)
                    send_rand_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                    4'($urandom_range(1, 7))});
                else
                    send_rand_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                    OPC_CONT});
            ERR_MASK:
            begin
                send_rand_byte(legal_hdr0(1'b1));
                send_rand_byte({~role_now, 7'($urandom_range(0, 127))});
            end
            default:
            begin
                send_rand_byte(legal_hdr0(1'b1));
                send_rand_byte({role_now, LEN_EXT64});
                send_rand_byte(8'h80 | 8'($urandom_range(0, 127)));
                repeat (7) send_rand_byte(8'($urandom_range(0, 255)));
                if (role_now)
                    repeat (4) send_rand_byte(8'($urandom_range(0, 255)));
                repeat (ENDLESS_BYTES) send_rand_byte(8'($urandom_range(0, 255)));
            end
        endcase
        repeat (NOISE_BYTES) send_rand_byte(8'($urandom_range(0, 255)));
        rx_if.valid = 1'b0;
        wait_drained();

        if (fail_cnt == 0)
            $display("[websocket_frame_deframer] OK");
        else
            $display("[websocket_frame_deframer] ERROR");
        $finish;
    end

endmodule

@@ websocket_frame_deframer.f @@
+incdir+hw/rtl
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_stream_if.sv
hw/rtl/wsfd_parser.sv
hw/rtl/wsfd_out_stage.sv
hw/rtl/websocket_frame_deframer.sv
hw/rtl/wsfd_checker.sv
tb/sv/tb_websocket_frame_deframer.sv
